FILE: src/bytecode_instruction_executor_assert.svh
// Assertion macros shared by the checker of the bytecode executor.
`ifndef BYTECODE_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define BYTECODE_INSTRUCTION_EXECUTOR_ASSERT_SVH
// Same-cycle implication, sampled on aclk, off during reset.
`define BIE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on aclk, off during reset.
`define BIE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: src/bie_pkg.sv
// Types, opcodes and constants of the bytecode instruction executor.
package bie_pkg;
    localparam int STORE_WORDS_DEF = 512;
    localparam int GENERAL_REGISTERS_DEF = 17;
    localparam int INSTRUCTION_BYTES = 10;
    localparam int LEN_W = 20;

    localparam logic [7:0] OP_HALT  = 8'h00;
    localparam logic [7:0] OP_LI    = 8'h41;
    localparam logic [7:0] OP_MOV   = 8'h42;
    localparam logic [7:0] OP_AND   = 8'h01;
    localparam logic [7:0] OP_OR    = 8'h02;
    localparam logic [7:0] OP_XOR   = 8'h03;
    localparam logic [7:0] OP_ADD   = 8'hAD;
    localparam logic [7:0] OP_SUB   = 8'hBA;
    localparam logic [7:0] OP_MUL   = 8'hAC;
    localparam logic [7:0] OP_DIV   = 8'hDD;
    localparam logic [7:0] OP_INC   = 8'h43;
    localparam logic [7:0] OP_DEC   = 8'h44;
    localparam logic [7:0] OP_NOT   = 8'h45;
    localparam logic [7:0] OP_SHR   = 8'hAA;
    localparam logic [7:0] OP_SHL   = 8'hBB;
    localparam logic [7:0] OP_CMPI  = 8'h05;
    localparam logic [7:0] OP_CMPR  = 8'h07;
    localparam logic [7:0] OP_JMP   = 8'h63;
    localparam logic [7:0] OP_JEQ   = 8'h06;
    localparam logic [7:0] OP_JLT   = 8'h09;
    localparam logic [7:0] OP_JGT   = 8'hDE;
    localparam logic [7:0] OP_PUSH  = 8'hFF;
    localparam logic [7:0] OP_POP   = 8'hFE;
    localparam logic [7:0] OP_LOAD  = 8'h59;
    localparam logic [7:0] OP_STORE = 8'h60;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_HALT      = 3'd1;
    localparam logic [2:0] ST_END       = 3'd2;
    localparam logic [2:0] ST_BADREG    = 3'd3;
    localparam logic [2:0] ST_BADINDEX  = 3'd4;
    localparam logic [2:0] ST_OVERFLOW  = 3'd5;
    localparam logic [2:0] ST_UNDERFLOW = 3'd6;

    localparam logic [2:0] FLAG_EQ = 3'b001;
    localparam logic [2:0] FLAG_LT = 3'b010;
    localparam logic [2:0] FLAG_GT = 3'b100;

    typedef enum logic [4:0] {
        K_HALT, K_LI, K_MOV, K_AND, K_OR, K_XOR, K_ADD, K_SUB, K_MUL, K_DIV,
        K_INC, K_DEC, K_NOT, K_SHR, K_SHL, K_CMPI, K_CMPR, K_JMP, K_JEQ,
        K_JLT, K_JGT, K_PUSH, K_POP, K_LOAD, K_STORE, K_NOP
    } kind_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MEM, S_MUL, S_DIV, S_DIVR, S_DIVQ, S_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  operand_a;
        logic [63:0] immediate;
    } in_t;

    typedef struct packed {
        logic [63:0] next_pc;
        logic        halted;
        logic [2:0]  status;
        logic        write_enable;
        logic [4:0]  write_register;
        logic [63:0] write_value;
    } out_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [63:0] imm;
        logic        a_ok;
        logic        b_ok;
        logic        bad_reg;
    } dec_t;
endpackage

FILE: src/bie_front.sv
// Front end: accepts instructions, classifies them and queues them.
module bie_front #(
    parameter int GENERAL_REGISTERS = bie_pkg::GENERAL_REGISTERS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bie_pkg::in_t  s_data,
    input  logic          busy,
    output logic          q_valid,
    input  logic          q_ready,
    output bie_pkg::dec_t q_data
);
    import bie_pkg::*;

    localparam int SP_REG = GENERAL_REGISTERS + 2;

    dec_t       dec;
    logic       one;
    logic       two;
    logic       b_ok;
    dec_t       q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    // Classify the instruction and check its register numbers
    always_comb begin
        dec.a   = s_data.operand_a;
        dec.b   = s_data.immediate[63:56];
        dec.imm = s_data.immediate;
        one  = (s_data.operand_a != 8'd0) &&
               ({24'd0, s_data.operand_a} <= 32'(GENERAL_REGISTERS));
        b_ok = (dec.b != 8'd0) && ({24'd0, dec.b} <= 32'(GENERAL_REGISTERS));
        two  = one && b_ok;
        dec.a_ok = one;
        dec.b_ok = b_ok;
        dec.bad_reg = 1'b0;
        case (s_data.opcode)
            OP_HALT:  dec.kind = K_HALT;
            OP_LI:    begin dec.kind = K_LI;    dec.bad_reg = !one; end
            OP_MOV:   begin dec.kind = K_MOV;   dec.bad_reg = !two; end
            OP_AND:   begin dec.kind = K_AND;   dec.bad_reg = !two; end
            OP_OR:    begin dec.kind = K_OR;    dec.bad_reg = !two; end
            OP_XOR:   begin dec.kind = K_XOR;   dec.bad_reg = !two; end
            OP_ADD:   begin dec.kind = K_ADD;   dec.bad_reg = !two; end
            OP_SUB:   begin dec.kind = K_SUB;   dec.bad_reg = !two; end
            OP_MUL:   begin dec.kind = K_MUL;   dec.bad_reg = !two; end
            OP_DIV:   begin dec.kind = K_DIV;   dec.bad_reg = !two; end
            OP_INC:   begin dec.kind = K_INC;   dec.bad_reg = !one; end
            OP_DEC:   begin dec.kind = K_DEC;   dec.bad_reg = !one; end
            OP_NOT:   begin dec.kind = K_NOT;   dec.bad_reg = !one; end
            OP_SHR:   begin dec.kind = K_SHR;   dec.bad_reg = !one; end
            OP_SHL:   begin dec.kind = K_SHL;   dec.bad_reg = !one; end
            OP_CMPI:  begin dec.kind = K_CMPI;  dec.bad_reg = !one; end
            OP_CMPR:  begin dec.kind = K_CMPR;  dec.bad_reg = !two; end
            OP_JMP:   dec.kind = K_JMP;
            OP_JEQ:   dec.kind = K_JEQ;
            OP_JLT:   dec.kind = K_JLT;
            OP_JGT:   dec.kind = K_JGT;
            OP_PUSH:  begin
                dec.kind = K_PUSH;
                dec.bad_reg = !one && ({24'd0, s_data.operand_a} != 32'(SP_REG));
            end
            OP_POP:   begin dec.kind = K_POP;   dec.bad_reg = !one; end
            OP_LOAD:  begin dec.kind = K_LOAD;  dec.bad_reg = !two; end
            OP_STORE: begin dec.kind = K_STORE; dec.bad_reg = !two; end
            default:  dec.kind = K_NOP;
        endcase
    end

    // Two-entry queue towards the back end
    assign s_ready = (count_reg != 2'd2) && !busy;
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued payload
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end
endmodule

FILE: src/bie_back.sv
// Back end: register file, stack store, multi-cycle multiply and divide.
module bie_back #(
    parameter int STORE_WORDS       = bie_pkg::STORE_WORDS_DEF,
    parameter int GENERAL_REGISTERS = bie_pkg::GENERAL_REGISTERS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [bie_pkg::LEN_W-1:0] program_length,
    output logic                     busy,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  bie_pkg::dec_t            q_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bie_pkg::out_t            m_data
);
    import bie_pkg::*;

    localparam int SAW    = $clog2(STORE_WORDS);
    localparam int SPW    = SAW + 1;
    localparam int RAW    = $clog2(GENERAL_REGISTERS);
    localparam int SP_REG = GENERAL_REGISTERS + 2;
    localparam logic [SPW-1:0] SP_RESET = SPW'(STORE_WORDS);
    localparam logic [SPW-1:0] SP_HALF  = SPW'(STORE_WORDS / 2);
    localparam logic [RAW-1:0] REM_IDX  = RAW'(GENERAL_REGISTERS - 1);

    state_t           state_reg, state_next;
    logic [63:0]      pc_reg, pc_next;
    logic [2:0]       flags_reg, flags_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic [2:0]       halt_reg, halt_next;
    dec_t             cur_reg, cur_next;
    logic [63:0]      x_reg, x_next;
    logic [63:0]      y_reg, y_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      quo_reg, quo_next;
    logic [63:0]      rem_reg, rem_next;
    logic [6:0]       cnt_reg, cnt_next;
    logic [SAW-1:0]   clr_reg, clr_next;
    logic             res_we_reg, res_we_next;
    logic [4:0]       res_wreg_reg, res_wreg_next;
    logic [63:0]      res_wval_reg, res_wval_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    logic [63:0]            rf_mem [GENERAL_REGISTERS];
    logic [GENERAL_REGISTERS-1:0] rf_valid_reg;
    logic [63:0]            rf_rd_a_reg, rf_rd_b_reg;
    logic [RAW-1:0]         rf_ia_reg, rf_ib_reg;
    logic                   rf_re;
    logic [RAW-1:0]         rf_ra, rf_rb;
    logic                   rf_we;
    logic [RAW-1:0]         rf_wa;
    logic [63:0]            rf_wd;

    logic [63:0]      st_mem [STORE_WORDS];
    logic [63:0]      st_rd_reg;
    logic             st_re;
    logic [SAW-1:0]   st_ra;
    logic             st_we;
    logic [SAW-1:0]   st_wa;
    logic [63:0]      st_wd;

    logic             fin;
    logic [63:0]      npc;
    logic [63:0]      va;
    logic [63:0]      target;
    logic [2:0]       cmp;
    logic [64:0]      rem_sh;
    logic [63:0]      prod;
    logic [63:0]      len64;

    assign busy    = (state_reg == S_CLEAR);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign len64   = {{(64-LEN_W){1'b0}}, program_length};
    assign target  = {cur_reg.imm[60:0], 3'b000} + {cur_reg.imm[62:0], 1'b0};
    assign rem_sh  = {rem_reg, quo_reg[63]};

    // Select the 32x32 partial product of this multiply step
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    prod = x_reg[31:0] * y_reg[31:0];
            2'd1:    prod = {x_reg[31:0] * y_reg[63:32], 32'd0};
            default: prod = {x_reg[63:32] * y_reg[31:0], 32'd0};
        endcase
    end

    // Compare register with immediate or second register
    always_comb begin
        logic [63:0] rhs;
        rhs = (cur_reg.kind == K_CMPI) ? cur_reg.imm : y_reg;
        if (x_reg == rhs) cmp = FLAG_EQ;
        else if (x_reg < rhs) cmp = FLAG_LT;
        else cmp = FLAG_GT;
    end

    // Sequence one instruction at a time
    always_comb begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        flags_next    = flags_reg;
        sp_next       = sp_reg;
        halt_next     = halt_reg;
        cur_next      = cur_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        acc_next      = acc_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        res_we_next   = res_we_reg;
        res_wreg_next = res_wreg_reg;
        res_wval_next = res_wval_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        q_ready = 1'b0;
        rf_re = 1'b0;
        rf_ra = RAW'(q_data.a - 8'd1);
        rf_rb = RAW'(q_data.b - 8'd1);
        rf_we = 1'b0;
        rf_wa = RAW'(cur_reg.a - 8'd1);
        rf_wd = 64'd0;
        st_re = 1'b0;
        st_ra = sp_reg[SAW-1:0];
        st_we = 1'b0;
        st_wa = clr_reg;
        st_wd = 64'd0;
        fin   = 1'b0;
        npc   = pc_reg + 64'(INSTRUCTION_BYTES);
        va    = 64'd0;

        case (state_reg)
            S_CLEAR: begin
                st_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SAW'(STORE_WORDS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_ready = 1'b1;
                    cur_next = q_data;
                    res_we_next = 1'b0;
                    res_wreg_next = 5'd0;
                    res_wval_next = 64'd0;
                    if (halt_reg != ST_OK) begin
                        state_next = S_OUT;
                    end else if (pc_reg >= len64) begin
                        halt_next = ST_END;
                        state_next = S_OUT;
                    end else begin
                        rf_re = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                x_next = (cur_reg.a_ok && rf_valid_reg[rf_ia_reg]) ? rf_rd_a_reg : 64'd0;
                y_next = (cur_reg.b_ok && rf_valid_reg[rf_ib_reg]) ? rf_rd_b_reg : 64'd0;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (cur_reg.bad_reg) begin
                    halt_next = ST_BADREG;
                    state_next = S_OUT;
                end else begin
                    case (cur_reg.kind)
                        K_HALT: begin
                            halt_next = ST_HALT;
                            state_next = S_OUT;
                        end
                        K_LI, K_MOV, K_AND, K_OR, K_XOR, K_ADD, K_SUB,
                        K_INC, K_DEC, K_NOT, K_SHR, K_SHL: begin
                            case (cur_reg.kind)
                                K_LI:    va = cur_reg.imm;
                                K_MOV:   va = y_reg;
                                K_AND:   va = x_reg & y_reg;
                                K_OR:    va = x_reg | y_reg;
                                K_XOR:   va = x_reg ^ y_reg;
                                K_ADD:   va = x_reg + y_reg;
                                K_SUB:   va = x_reg - y_reg;
                                K_INC:   va = x_reg + 64'd1;
                                K_DEC:   va = x_reg - 64'd1;
                                K_NOT:   va = ~x_reg;
                                K_SHR:   va = x_reg >> cur_reg.imm[5:0];
                                default: va = x_reg << cur_reg.imm[5:0];
                            endcase
                            rf_we = 1'b1;
                            rf_wd = va;
                            res_we_next = 1'b1;
                            res_wreg_next = cur_reg.a[4:0];
                            res_wval_next = va;
                            fin = 1'b1;
                        end
                        K_MUL: begin
                            acc_next = 64'd0;
                            cnt_next = 7'd0;
                            state_next = S_MUL;
                        end
                        K_DIV: begin
                            // Replace a zero divisor by one before dividing
                            if (y_reg == 64'd0) begin
                                rf_we = 1'b1;
                                rf_wa = RAW'(cur_reg.b - 8'd1);
                                rf_wd = 64'd1;
                                y_next = 64'd1;
                            end
                            quo_next = x_reg;
                            rem_next = 64'd0;
                            cnt_next = 7'd0;
                            state_next = S_DIV;
                        end
                        K_CMPI, K_CMPR: begin
                            flags_next = flags_reg | cmp;
                            fin = 1'b1;
                        end
                        K_JMP: begin
                            npc = target;
                            fin = 1'b1;
                        end
                        K_JEQ, K_JLT, K_JGT: begin
                            if ((cur_reg.kind == K_JEQ && flags_reg[0]) ||
                                (cur_reg.kind == K_JLT && flags_reg[1]) ||
                                (cur_reg.kind == K_JGT && flags_reg[2])) begin
                                flags_next = 3'd0;
                                npc = target;
                            end
                            fin = 1'b1;
                        end
                        K_PUSH: begin
                            if (sp_reg <= SP_HALF) begin
                                halt_next = ST_OVERFLOW;
                                state_next = S_OUT;
                            end else begin
                                st_we = 1'b1;
                                st_wa = SAW'(sp_reg - 1'b1);
                                st_wd = cur_reg.a_ok ? x_reg : {{(64-SPW){1'b0}}, sp_reg};
                                sp_next = sp_reg - 1'b1;
                                res_we_next = 1'b1;
                                res_wreg_next = 5'(SP_REG);
                                res_wval_next = {{(64-SPW){1'b0}}, sp_reg};
                                fin = 1'b1;
                            end
                        end
                        K_POP: begin
                            if (sp_reg >= SP_RESET) begin
                                halt_next = ST_UNDERFLOW;
                                state_next = S_OUT;
                            end else begin
                                st_re = 1'b1;
                                sp_next = sp_reg + 1'b1;
                                state_next = S_MEM;
                            end
                        end
                        K_LOAD, K_STORE: begin
                            if (y_reg > 64'(STORE_WORDS / 2)) begin
                                halt_next = ST_BADINDEX;
                                state_next = S_OUT;
                            end else begin
                                st_ra = SAW'(64'(STORE_WORDS - 1) - y_reg);
                                st_wa = st_ra;
                                if (cur_reg.kind == K_LOAD) begin
                                    st_re = 1'b1;
                                    state_next = S_MEM;
                                end else begin
                                    st_we = 1'b1;
                                    st_wd = x_reg;
                                    fin = 1'b1;
                                end
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                end
            end
            S_MEM: begin
                rf_we = 1'b1;
                rf_wd = st_rd_reg;
                res_we_next = 1'b1;
                res_wreg_next = cur_reg.a[4:0];
                res_wval_next = st_rd_reg;
                fin = 1'b1;
            end
            S_MUL: begin
                // Accumulate three partial products, the high one drops out
                acc_next = acc_reg + prod;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd2) begin
                    rf_we = 1'b1;
                    rf_wd = acc_next;
                    res_we_next = 1'b1;
                    res_wreg_next = cur_reg.a[4:0];
                    res_wval_next = acc_next;
                    fin = 1'b1;
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit a cycle
                if (rem_sh >= {1'b0, y_reg}) begin
                    rem_next = 64'(rem_sh - {1'b0, y_reg});
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = rem_sh[63:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) state_next = S_DIVR;
            end
            S_DIVR: begin
                rf_we = 1'b1;
                rf_wa = REM_IDX;
                rf_wd = rem_reg;
                state_next = S_DIVQ;
            end
            S_DIVQ: begin
                rf_we = 1'b1;
                rf_wd = quo_reg;
                res_we_next = 1'b1;
                res_wreg_next = cur_reg.a[4:0];
                res_wval_next = quo_reg;
                fin = 1'b1;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next.next_pc = pc_reg;
                    m_data_next.halted = (halt_reg != ST_OK);
                    m_data_next.status = halt_reg;
                    m_data_next.write_enable = res_we_reg;
                    m_data_next.write_register = res_wreg_reg;
                    m_data_next.write_value = res_wval_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Commit the new pc and check for the end of the program
        if (fin) begin
            pc_next = npc;
            if (npc >= len64) halt_next = ST_END;
            state_next = S_OUT;
        end
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            pc_reg       <= 64'd0;
            flags_reg    <= 3'd0;
            sp_reg       <= SP_RESET;
            halt_reg     <= ST_OK;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
            rf_valid_reg <= '0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            flags_reg   <= flags_next;
            sp_reg      <= sp_next;
            halt_reg    <= halt_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (rf_we) rf_valid_reg[rf_wa] <= 1'b1;
        end
    end

    // Hold working payload
    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        acc_reg      <= acc_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        res_we_reg   <= res_we_next;
        res_wreg_reg <= res_wreg_next;
        res_wval_reg <= res_wval_next;
        m_data_reg   <= m_data_next;
    end

    // Register file memory, two registered reads
    always_ff @(posedge aclk) begin
        if (rf_we) rf_mem[rf_wa] <= rf_wd;
        if (rf_re) begin
            rf_rd_a_reg <= rf_mem[rf_ra];
            rf_rd_b_reg <= rf_mem[rf_rb];
            rf_ia_reg   <= rf_ra;
            rf_ib_reg   <= rf_rb;
        end
    end

    // Stack and data store memory
    always_ff @(posedge aclk) begin
        if (st_we) st_mem[st_wa] <= st_wd;
        if (st_re) st_rd_reg <= st_mem[st_ra];
    end
endmodule

FILE: src/bytecode_instruction_executor.sv
// Top level of the bytecode instruction executor.
// Executes one 10-byte instruction per input transaction and returns one result
// transaction with the next pc, halt status and any register write. After reset
// the data store (STORE_WORDS words, 512 by default) is cleared with s_ready
// low; the configuration port is live throughout. In the back end a queued
// instruction then passes through queue pop, register read, execute and result
// load for most operations; loads and pops add a store read, multiplies add three
// 32x32 partial products and divides add one quotient bit a cycle, then separate
// remainder and quotient writes.
// A halted machine answers each transaction with the same pc and status.
module bytecode_instruction_executor #(
    parameter int STORE_WORDS       = bie_pkg::STORE_WORDS_DEF,
    parameter int GENERAL_REGISTERS = bie_pkg::GENERAL_REGISTERS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [bie_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bie_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bie_pkg::out_t             m_data
);
    import bie_pkg::*;

    logic [LEN_W-1:0] len_reg;
    logic             busy;
    logic             q_valid;
    logic             q_ready;
    dec_t             q_data;

    // Hold the program length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (cfg_wr_en) begin
            len_reg <= cfg_wr_data;
        end
    end

    bie_front #(
        .GENERAL_REGISTERS(GENERAL_REGISTERS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .busy(busy),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    bie_back #(
        .STORE_WORDS(STORE_WORDS),
        .GENERAL_REGISTERS(GENERAL_REGISTERS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .program_length(len_reg),
        .busy(busy),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

FILE: src/bie_checker.sv
// Port-level checker of the bytecode executor and its bind.
`include "bytecode_instruction_executor_assert.svh"
module bie_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input bie_pkg::out_t m_data
);
    import bie_pkg::*;

    // Hold a stalled result transaction
    `BIE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // Halted flag matches a non-zero status
    `BIE_ASSERT_NOW(a_halt_status, m_valid, m_data.halted == (m_data.status != ST_OK))
    // No write fields without a write
    `BIE_ASSERT_NOW(a_no_write, m_valid && !m_data.write_enable,
        m_data.write_register == 5'd0 && m_data.write_value == 64'd0)
    // A faulting or halting result reports no write
    `BIE_ASSERT_NOW(a_fault_nowrite, m_valid && m_data.status != ST_OK && m_data.status != ST_END,
        !m_data.write_enable)
endmodule

bind bytecode_instruction_executor bie_checker u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
